### src/gf2mc_pkg.sv
package gf2mc_pkg;

    localparam int ROW_W       = 8;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;
    localparam int OUT_DATA_W  = 16;
    localparam int DEF_MAX_DIM = 8;

    localparam logic [CNT_W-1:0] SIZE_RESET = 4'd3;
    localparam logic             MODE_RESET = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ABSTRACT_MODE = 4'd1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_FETCH,
        S_REDUCE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_row;
        logic fetch;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic complete;
        logic v_zero;
        logic piv_hit;
        logic last_idx;
        logic out_free;
    } status_t;

endpackage

### src/gf2_matrix_classifier.sv
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: row_bits[7:0]
// m_axis    out  tdata: invertible, rows_sorted, row_xor[7:0], accepted, zero fill
// cfg       in   cfg_index (0 matrix_size, 1 abstract_mode), cfg_data
//
// One row is taken per cycle while loading. After the last row of a matrix the
// single-step reducer works through the stored rows against the pivot table, each
// row passing through read, fetch and reduce states, then hands over the result.
// Rows are refused during that time; the hand-over also waits while the previous
// result is still held. A result waiting in the output register does not stop the
// next matrix loading. Reset clears the load state and the pivot table.
module gf2_matrix_classifier
    import gf2mc_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ROW_W-1:0]      s_tdata,   // row_bits
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // invertible, rows_sorted, row_xor, accepted
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CNT_W-1:0] size_reg;
    logic             mode_reg;
    logic [CNT_W-1:0] size_n;
    cmd_t             cmd;
    status_t          status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            mode_reg <= MODE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MATRIX_SIZE:   size_reg <= cfg_data[CNT_W-1:0];
                REG_ABSTRACT_MODE: mode_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // effective size, clamped to 1..MAX_DIM
    always_comb
    begin
        if (size_reg == '0)
        begin
            size_n = CNT_W'(1);
        end
        else if (int'(size_reg) > MAX_DIM)
        begin
            size_n = CNT_W'(MAX_DIM);
        end
        else
        begin
            size_n = size_reg;
        end
    end

    gf2mc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gf2mc_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .size_n        (size_n),
        .abstract_mode (mode_reg),
        .row_bits      (s_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

### src/gf2mc_ctrl.sv
module gf2mc_ctrl
    import gf2mc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                s_tready     = 1'b1;
                cmd.load_row = s_tvalid;
                if (s_tvalid && status.complete)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                cmd.step = 1'b1;
                if (status.v_zero)
                begin
                    state_next = S_DONE;
                end
                else if (!status.piv_hit)
                begin
                    state_next = status.last_idx ? S_DONE : S_READ;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

### src/gf2mc_dp.sv
module gf2mc_dp
    import gf2mc_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CNT_W-1:0]      size_n,
    input  logic                  abstract_mode,
    input  logic [ROW_W-1:0]      row_bits,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int PIV_W = $clog2(ROW_W);

    function automatic logic [PIV_W-1:0] lowest_bit(input logic [ROW_W-1:0] v);
        logic [PIV_W-1:0] pos;
        pos = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = PIV_W'(i);
            end
        end
        return pos;
    endfunction

    logic [ROW_W-1:0] row_mem [MAX_DIM];
    logic [ROW_W-1:0] rd_data_reg;

    logic [CNT_W-1:0] rows_loaded_reg;
    logic [ROW_W-1:0] prev_row_reg;
    logic             order_ok_reg;
    logic [ROW_W-1:0] xor_reg;

    logic [IDX_W-1:0] elim_idx_reg;
    logic [ROW_W-1:0] v_reg;
    logic             det_reg;
    logic [ROW_W-1:0] piv_reg       [ROW_W];
    logic [ROW_W-1:0] piv_valid_reg;

    logic             out_valid_reg;
    logic             out_inv_reg;
    logic             out_sorted_reg;
    logic [ROW_W-1:0] out_xor_reg;
    logic             out_acc_reg;

    logic [ROW_W-1:0] col_mask;
    logic [ROW_W-1:0] row_masked;
    logic [CNT_W-1:0] rows_next;
    logic             start;
    logic [PIV_W-1:0] piv_col;

    always_comb
    begin
        for (int c = 0; c < ROW_W; c++)
        begin
            col_mask[c] = (int'(size_n) > c);
        end
    end

    assign row_masked = row_bits & col_mask;
    assign rows_next  = rows_loaded_reg + CNT_W'(1);
    assign start      = cmd.load_row && status.complete;
    assign piv_col    = lowest_bit(v_reg);

    assign status.complete = (rows_next >= size_n);
    assign status.v_zero   = (v_reg == '0);
    assign status.piv_hit  = piv_valid_reg[piv_col];
    assign status.last_idx = (CNT_W'(elim_idx_reg) == size_n - CNT_W'(1));
    assign status.out_free = !out_valid_reg || m_tready;

    // row store
    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            row_mem[rows_loaded_reg[IDX_W-1:0]] <= row_masked;
        end
        rd_data_reg <= row_mem[elim_idx_reg];
    end

    // load accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_loaded_reg <= '0;
            prev_row_reg    <= '0;
            order_ok_reg    <= 1'b1;
            xor_reg         <= '0;
        end
        else if (cmd.finish)
        begin
            prev_row_reg <= '0;
            order_ok_reg <= 1'b1;
            xor_reg      <= '0;
        end
        else if (cmd.load_row)
        begin
            rows_loaded_reg <= start ? '0 : rows_next;
            prev_row_reg    <= row_masked;
            xor_reg         <= xor_reg ^ row_masked;
            if (row_masked < prev_row_reg)
            begin
                order_ok_reg <= 1'b0;
            end
        end
    end

    // elimination: one pivot step per cycle while in the reduce state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piv_valid_reg <= '0;
            elim_idx_reg  <= '0;
        end
        else if (start)
        begin
            piv_valid_reg <= '0;
            elim_idx_reg  <= '0;
        end
        else if (cmd.step && !status.v_zero && !status.piv_hit)
        begin
            piv_valid_reg[piv_col] <= 1'b1;
            elim_idx_reg           <= elim_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            det_reg <= 1'b1;
        end
        else if (cmd.step && status.v_zero)
        begin
            det_reg <= 1'b0;
        end
        if (cmd.fetch)
        begin
            v_reg <= rd_data_reg & col_mask;
        end
        else if (cmd.step && status.piv_hit)
        begin
            v_reg <= v_reg ^ piv_reg[piv_col];
        end
        if (cmd.step && !status.v_zero && !status.piv_hit)
        begin
            piv_reg[piv_col] <= v_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_inv_reg    <= det_reg;
            out_sorted_reg <= order_ok_reg;
            out_xor_reg    <= xor_reg;
            out_acc_reg    <= det_reg && (order_ok_reg || !abstract_mode);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - ROW_W - 3)'(0), out_acc_reg, out_xor_reg,
                       out_sorted_reg, out_inv_reg};

endmodule
